// ===== rtl/core/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, constants and helpers for the double-ended queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(DEPTH);

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // request kinds carried in s_tuser
    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } req_t;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // command broadcast from the controller to the cell row
    typedef struct packed {
        logic             shift_r;   // every cell takes its left neighbor
        logic             shift_l;   // every cell takes its right neighbor
        logic [DEPTH-1:0] load;      // one-hot: cell that takes the pushed value
    } cell_cmd_t;

    function automatic data_t to_store(logic signed [31:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] to_out(data_t d);
        logic signed [63:0] w;
        w = 64'(signed'(d));
        return w[31:0];
    endfunction

endpackage

// ===== rtl/core/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue built as a row of shifting cells.
//
//   channel  dir  tdata (low bit first)                     tuser
//   s_       in   push_value[31:0]                          req_type[1:0]
//   m_       out  status, front_value, back_value, count    -
//
// One request per result beat; the result beat of a request is registered and
// shows up in the cycle after the request is taken. Cell 0 is the front, cell
// count-1 the back; a push front or pop front moves the whole row by one cell.
// A new request is taken in the cycle its predecessor's result is taken, so
// back-to-back traffic runs at one beat per cycle; a stalled m_ side holds s_.
// Reset clears the count and the handshake; cell contents are left as is.
// ----------------------------------------------------------------------------
module double_ended_queue_core
    import deq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // push_value[31:0]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // status[1:0], front_value[33:2],
                                   // back_value[65:34], count[70:66]
);

    cell_cmd_t   cmd;
    cnt_t        count_q;
    logic [1:0]  status_q;
    data_t       push_d;
    data_t       cell_q [DEPTH];
    cnt_t        cnt_m1;
    logic [31:0] front_out, back_out;

    assign push_d = to_store(signed'(s_tdata[31:0]));

    deq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req      (req_t'(s_tuser)),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .count_q  (count_q),
        .status_q (status_q)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        data_t left_d, right_d;
        if (i == 0) begin : g_first
            assign left_d = push_d;
        end else begin : g_mid
            assign left_d = cell_q[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_inner
            assign right_d = cell_q[i+1];
        end
        deq_cell u_cell (
            .aclk    (aclk),
            .cmd     (cmd),
            .load_en (cmd.load[i]),
            .push_d  (push_d),
            .left_d  (left_d),
            .right_d (right_d),
            .data_q  (cell_q[i])
        );
    end

    // cells hold still while the result beat waits, so read them directly
    assign cnt_m1    = count_q - CNT_W'(1);
    assign front_out = (count_q == '0) ? 32'd0 : to_out(cell_q[0]);
    assign back_out  = (count_q == '0) ? 32'd0 : to_out(cell_q[cnt_m1[IDX_W-1:0]]);

    assign m_tdata = {1'b0, count_q, back_out, front_out, status_q};

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_q <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[1] && count_q == '0
        |=> status_q == ST_EMPTY && count_q == '0)
        else $error("pop on empty queue not refused");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[1] && count_q != CNT_W'(DEPTH)
        |=> status_q == ST_OK && count_q == $past(count_q) + CNT_W'(1))
        else $error("push did not grow the queue by one");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == REQ_PUSH_BACK && count_q != CNT_W'(DEPTH)
        |=> back_out == to_out(to_store(signed'($past(s_tdata[31:0])))))
        else $error("back value does not match pushed beat");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == REQ_PUSH_FRONT && count_q != CNT_W'(DEPTH)
        |=> front_out == to_out(to_store(signed'($past(s_tdata[31:0])))))
        else $error("front value does not match pushed beat");

endmodule

// ===== rtl/core/deq_cell.sv =====
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue row: holds, loads, or takes a neighbor.
// ----------------------------------------------------------------------------
module deq_cell
    import deq_pkg::*;
(
    input  logic      aclk,
    input  cell_cmd_t cmd,
    input  logic      load_en,
    input  data_t     push_d,
    input  data_t     left_d,
    input  data_t     right_d,
    output data_t     data_q
);

    data_t data_reg;
    data_t data_next;

    always_comb begin
        data_next = data_reg;
        if (load_en) begin
            data_next = push_d;
        end else if (cmd.shift_r) begin
            data_next = left_d;
        end else if (cmd.shift_l) begin
            data_next = right_d;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;

endmodule

// ===== rtl/core/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Request decode, fill count, status and output beat handshake.
// ----------------------------------------------------------------------------
module deq_ctrl
    import deq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  req_t       req,
    output logic       m_tvalid,
    input  logic       m_tready,
    output cell_cmd_t  cmd,
    output cnt_t       count_q,
    output logic [1:0] status_q
);

    logic       m_valid_reg, m_valid_next;
    cnt_t       count_reg, count_next;
    logic [1:0] status_reg, status_next;
    logic       accept;
    logic       empty, full;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));

    always_comb begin
        cmd          = '0;
        count_next   = count_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            status_next  = ST_OK;
            case (req)
                REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        // into an empty row the value always lands in cell 0
                        if (empty || req == REQ_PUSH_BACK) begin
                            cmd.load = DEPTH'(1) << count_reg[IDX_W-1:0];
                        end else begin
                            cmd.shift_r = 1'b1;
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                REQ_POP_FRONT, REQ_POP_BACK: begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        cmd.shift_l = (req == REQ_POP_FRONT);
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
        status_reg <= status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign count_q  = count_reg;
    assign status_q = status_reg;

endmodule

// ===== tb/double_ended_queue_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_core_test
// Self-checking bench for the deque core: pushes and pops at both ends are
// sent through the s_ stream, a tracker class mirrors the deque in a ring and predicts
// every result beat, and the m_ beats are compared field by field in order.
// ----------------------------------------------------------------------------
module double_ended_queue_core_test;
    import deq_pkg::*;

    localparam int ITEMS          = 1450;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;

    // ------------------------------------------------------------------------
    // tracker: mirrors the deque contents and keeps the results still owed
    // ------------------------------------------------------------------------
    class deque_tracker;
        typedef struct {
            logic [1:0]  status;
            logic [31:0] front;
            logic [31:0] back;
            cnt_t        count;
        } deque_result_t;

        data_t         ring [DEPTH];
        int            head_idx;
        int            tail_idx;
        int            fill;
        deque_result_t owed_results [$];
        int            errors;
        int            n_requests;
        int            n_ok;
        int            n_empty_pops;
        int            n_full_pushes;
        int            peak_fill;

        function new();
            head_idx = 0;
            tail_idx = 0;
            fill     = 0;
            errors   = 0;
        endfunction

        function logic [31:0] widen(data_t d);
            logic signed [DATA_WIDTH-1:0] s;
            logic signed [63:0]           w;
            s = d;
            w = s;
            return w[31:0];
        endfunction

        function void note_request(req_t kind, logic [31:0] value);
            logic signed [31:0] sv;
            logic signed [63:0] w;
            deque_result_t      r;
            sv = value;
            w  = sv;
            r.status = ST_OK;
            if (kind == REQ_PUSH_FRONT || kind == REQ_PUSH_BACK) begin
                if (fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (fill == 0) begin
                    tail_idx       = head_idx;
                    ring[head_idx] = w[DATA_WIDTH-1:0];
                    fill           = 1;
                end else if (kind == REQ_PUSH_FRONT) begin
                    head_idx       = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
                    ring[head_idx] = w[DATA_WIDTH-1:0];
                    fill++;
                end else begin
                    tail_idx       = (tail_idx == DEPTH - 1) ? 0 : tail_idx + 1;
                    ring[tail_idx] = w[DATA_WIDTH-1:0];
                    fill++;
                end
            end else begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else if (fill == 1) begin
                    // last value gone; positions stay where they are
                    fill = 0;
                end else if (kind == REQ_POP_FRONT) begin
                    head_idx = (head_idx == DEPTH - 1) ? 0 : head_idx + 1;
                    fill--;
                end else begin
                    tail_idx = (tail_idx == 0) ? DEPTH - 1 : tail_idx - 1;
                    fill--;
                end
            end
            r.front = (fill == 0) ? 32'd0 : widen(ring[head_idx]);
            r.back  = (fill == 0) ? 32'd0 : widen(ring[tail_idx]);
            r.count = cnt_t'(fill);
            owed_results.push_back(r);

            n_requests++;
            if (r.status == ST_OK)
                n_ok++;
            else if (r.status == ST_EMPTY)
                n_empty_pops++;
            else
                n_full_pushes++;
            if (fill > peak_fill)
                peak_fill = fill;
        endfunction

        function void check_result(logic [71:0] beat);
            deque_result_t r;
            if (owed_results.size() == 0) begin
                $error("result beat with no request outstanding: %h", beat);
                errors++;
                return;
            end
            r = owed_results.pop_front();
            if (beat[1:0] !== r.status) begin
                $error("status: expected %0d, got %0d", r.status, beat[1:0]);
                errors++;
            end
            if (beat[33:2] !== r.front) begin
                $error("front_value: expected %0d, got %0d",
                       $signed(r.front), $signed(beat[33:2]));
                errors++;
            end
            if (beat[65:34] !== r.back) begin
                $error("back_value: expected %0d, got %0d",
                       $signed(r.back), $signed(beat[65:34]));
                errors++;
            end
            if (beat[70:66] !== r.count) begin
                $error("count: expected %0d, got %0d", r.count, beat[70:66]);
                errors++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = REQ_PUSH_FRONT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    int send_idle_pct  = 11;
    int recv_stall_pct = 75;
    int quiet_cycles   = 0;
    int sent           = 0;

    deque_tracker tracker = new();

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    double_ended_queue_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // both channels sampled in one process so request and result order is fixed
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.note_request(req_t'(s_tuser), s_tdata[31:0]);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("double_ended_queue_core_test NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic send_request(input req_t kind, input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= kind;
        do
            @(posedge aclk);
        while (!s_tready);
        sent++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic void set_idling();
        if (sent < ITEMS / 3) begin
            send_idle_pct  = 11;
            recv_stall_pct = 75;
        end else if (sent < 2 * ITEMS / 3) begin
            send_idle_pct  = 75;
            recv_stall_pct = 11;
        end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    endfunction

    initial begin
        int push_bias [5] = '{95, 80, 50, 20, 5};
        int seg_len;
        int bias;
        req_t kind;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty pops, single-entry push/pop, value extremes
        send_request(REQ_POP_FRONT,  32'h1234_5678);
        send_request(REQ_POP_BACK,   32'hffff_ffff);
        send_request(REQ_PUSH_FRONT, 32'h7fff_ffff);
        send_request(REQ_POP_BACK,   32'h0000_0000);
        send_request(REQ_PUSH_BACK,  32'h8000_0000);
        send_request(REQ_PUSH_FRONT, 32'hffff_ffff);
        send_request(REQ_PUSH_BACK,  32'h0000_0000);
        send_request(REQ_PUSH_FRONT, 32'h0000_0001);
        send_request(REQ_POP_FRONT,  32'h0000_0000);
        send_request(REQ_POP_BACK,   32'h0000_0000);
        send_request(REQ_POP_FRONT,  32'h0000_0000);
        send_request(REQ_POP_BACK,   32'h0000_0000);
        send_request(REQ_POP_FRONT,  32'h0000_0000);
        send_request(REQ_PUSH_BACK,  32'haaaa_aaaa);
        send_request(REQ_PUSH_FRONT, 32'h5555_5555);
        send_request(REQ_POP_BACK,   32'hffff_ffff);
        send_request(REQ_POP_FRONT,  32'hffff_ffff);

        // fill to the top and push past it at randomly chosen ends
        for (int i = 0; i < DEPTH + 2; i++)
            send_request($urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_value());

        // random segments, each with its own push/pop mix, to walk full <-> empty
        while (sent < ITEMS) begin
            seg_len = $urandom_range(20, 60);
            bias    = push_bias[$urandom_range(4)];
            for (int i = 0; i < seg_len && sent < ITEMS; i++) begin
                set_idling();
                if ($urandom_range(99) < bias)
                    kind = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
                else
                    kind = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
                send_request(kind, pick_value());
            end
        end
        s_tvalid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests checked: %0d ok, %0d pops on empty, %0d pushes on full",
                 tracker.n_requests, tracker.n_ok, tracker.n_empty_pops,
                 tracker.n_full_pushes);
        $display("peak fill %0d of %0d, three idling mixes on both channels",
                 tracker.peak_fill, DEPTH);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("double_ended_queue_core_test OK");
        end else begin
            $display("double_ended_queue_core_test NOT OK");
        end
        $finish;
    end

endmodule
